/* hw/rtl/ftp_pkg.sv */
// ----------------------------------------------------------------------------
// ftp_pkg: shared types and constants of the function time profiler
// Table row layout, configuration bundle, command and register codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ftp_pkg;

	localparam int FUNC_COUNT = 256;
	localparam int FUNC_BITS  = $clog2(FUNC_COUNT);
	localparam int DEPTH_BITS = 16;
	localparam int CNT_W      = 64;
	localparam int STEP_BITS  = $clog2(CNT_W);
	localparam int ITER_W     = 32;
	localparam int THR_W      = 32;
	localparam int CPU_W      = 16;
	localparam int LIMIT_W    = THR_W + CPU_W;
	localparam int ADD_W      = LIMIT_W + 1;
	localparam int REM_W      = ITER_W + 1;
	localparam int APB_AW     = 4;
	localparam int APB_DW     = 32;

	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

	localparam logic [1:0] CMD_ENTRY = 2'd0;
	localparam logic [1:0] CMD_EXIT  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_ITER   = 2'd1;
	localparam logic [1:0] REG_THRESH = 2'd2;
	localparam logic [1:0] REG_CPU    = 2'd3;

	localparam logic [ITER_W-1:0] ITER_RESET   = ITER_W'(100);
	localparam logic [THR_W-1:0]  THRESH_RESET = THR_W'(5000);
	localparam logic [CPU_W-1:0]  CPU_RESET    = CPU_W'(2300);

	typedef struct packed {
		logic [DEPTH_BITS-1:0] depth;
		logic [CNT_W-1:0]      start;
		logic [CNT_W-1:0]      acc;
		logic [CNT_W-1:0]      count;
		logic                  shutoff;
	} row_t;

	typedef struct packed {
		logic              enable;
		logic [ITER_W-1:0] iter;
		logic [THR_W-1:0]  thresh;
		logic [CPU_W-1:0]  cpu;
	} cfg_t;

	typedef struct packed {
		logic done;
		logic below;
	} chk_res_t;

endpackage

`default_nettype wire

/* hw/rtl/ftp_cfg.sv */
// ----------------------------------------------------------------------------
// ftp_cfg: configuration registers
// APB write and read access to the shutoff enable, interval, threshold and
// clock rate registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ftp_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [ftp_pkg::APB_AW-1:0] paddr,
	input  wire logic [ftp_pkg::APB_DW-1:0] pwdata,
	output logic      [ftp_pkg::APB_DW-1:0] prdata,
	output logic                            pready,
	output ftp_pkg::cfg_t                   cfg
);
	import ftp_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable <= 1'b0;
			cfg_q.iter   <= ITER_RESET;
			cfg_q.thresh <= THRESH_RESET;
			cfg_q.cpu    <= CPU_RESET;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_ENABLE: cfg_q.enable <= pwdata[0];
				REG_ITER:   cfg_q.iter   <= pwdata[ITER_W-1:0];
				REG_THRESH: cfg_q.thresh <= pwdata[THR_W-1:0];
				REG_CPU:    cfg_q.cpu    <= pwdata[CPU_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ENABLE: prdata = APB_DW'(cfg_q.enable);
			REG_ITER:   prdata = APB_DW'(cfg_q.iter);
			REG_THRESH: prdata = APB_DW'(cfg_q.thresh);
			REG_CPU:    prdata = APB_DW'(cfg_q.cpu);
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/ftp_table.sv */
// ----------------------------------------------------------------------------
// ftp_table: per-function state store
// One row per function in a memory with one write and one registered read port;
// a valid bit per row makes unwritten rows read as zero after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ftp_table (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          rd_en,
	input  wire logic [ftp_pkg::FUNC_BITS-1:0] rd_addr,
	output ftp_pkg::row_t                      rd_row,
	input  wire logic                          wr_en,
	input  wire logic [ftp_pkg::FUNC_BITS-1:0] wr_addr,
	input  ftp_pkg::row_t                      wr_row
);
	import ftp_pkg::*;

	row_t                  mem [FUNC_COUNT];
	row_t                  rd_q;
	logic                  rd_vld_q;
	logic [FUNC_COUNT-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	// a row never written since reset reads as all zero
	assign rd_row = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

/* hw/rtl/ftp_check.sv */
// ----------------------------------------------------------------------------
// ftp_check: average-time check unit
// One shared 49-bit add/subtract unit runs first a bit-serial remainder of
// the entry count by the interval; only if it is zero, a shift-add product of
// the cycle limit and the entry count follows, then a compare with the total.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ftp_check (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [ftp_pkg::CNT_W-1:0] count_in,
	input  wire logic [ftp_pkg::CNT_W-1:0] acc_in,
	input  ftp_pkg::cfg_t                  cfg,
	output ftp_pkg::chk_res_t              res
);
	import ftp_pkg::*;

	typedef enum logic [1:0] {
		C_IDLE,
		C_MOD,
		C_MUL,
		C_CMP
	} cstate_t;

	cstate_t              state_q;
	logic [STEP_BITS-1:0] step_q;
	logic [REM_W-1:0]     rem_q;
	logic [CNT_W-1:0]     div_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     acc_q;
	logic [ADD_W-1:0]     hi_q;
	logic [LIMIT_W-1:0]   limit_q;
	chk_res_t             res_q;

	logic [REM_W-1:0]     rem_shift;
	logic [REM_W-1:0]     rem_next;
	logic [ADD_W-1:0]     add_a;
	logic [ADD_W-1:0]     add_b;
	logic                 add_sub;
	logic [ADD_W:0]       add_res;
	logic [ADD_W-1:0]     mul_sum;
	logic                 last_step;

	assign rem_shift = {rem_q[REM_W-2:0], div_q[CNT_W-1]};
	assign last_step = (step_q == '1);

	// shared adder: subtract for the remainder, add for the product
	always_comb begin
		if (state_q == C_MOD) begin
			add_a   = ADD_W'(rem_shift);
			add_b   = ADD_W'(cfg.iter);
			add_sub = 1'b1;
		end else begin
			add_a   = hi_q;
			add_b   = ADD_W'(limit_q);
			add_sub = 1'b0;
		end
		add_res = {1'b0, add_a} + {1'b0, add_b ^ {ADD_W{add_sub}}} + (ADD_W + 1)'(add_sub);
	end

	// carry out of the subtract means no borrow: keep the difference
	assign rem_next = add_res[ADD_W] ? add_res[REM_W-1:0] : rem_shift;
	assign mul_sum  = div_q[0] ? add_res[ADD_W-1:0] : hi_q;
	assign res      = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= '0;
			rem_q   <= '0;
			div_q   <= '0;
			cnt_q   <= '0;
			acc_q   <= '0;
			hi_q    <= '0;
			limit_q <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					res_q.done <= 1'b0;
					if (start) begin
						acc_q   <= acc_in;
						cnt_q   <= count_in;
						div_q   <= count_in;
						rem_q   <= '0;
						step_q  <= '0;
						limit_q <= LIMIT_W'(cfg.thresh) * LIMIT_W'(cfg.cpu);
						state_q <= C_MOD;
					end
				end
				C_MOD: begin
					rem_q      <= rem_next;
					step_q     <= step_q + 1'b1;
					res_q.done <= last_step && (rem_next != '0);
					if (last_step && (rem_next == '0)) begin
						div_q   <= cnt_q;
						hi_q    <= '0;
						state_q <= C_MUL;
					end else begin
						div_q <= div_q << 1;
						if (last_step) begin
							res_q.below <= 1'b0;
							state_q     <= C_IDLE;
						end
					end
				end
				C_MUL: begin
					// shift the partial product right by one bit
					res_q.done <= 1'b0;
					hi_q       <= {1'b0, mul_sum[ADD_W-1:1]};
					div_q      <= {mul_sum[0], div_q[CNT_W-1:1]};
					step_q     <= step_q + 1'b1;
					if (last_step) begin
						state_q <= C_CMP;
					end
				end
				C_CMP: begin
					res_q.done  <= 1'b1;
					res_q.below <= (hi_q != '0) || (acc_q < div_q);
					state_q     <= C_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/function_time_profiler.sv */
// ----------------------------------------------------------------------------
// function_time_profiler: per-function call timing table
// Usage: an event word (cmd, func_index, timestamp) enters on the evt
// valid/ready channel; one result word per event leaves on the res channel.
// Entry counts outermost entries and latches the timestamp; exit lowers the
// nesting depth and adds the elapsed cycles on the outermost exit; read
// returns the totals. Settings are written over the APB port while idle.
// Each event passes read of the row, then update, then write-back with output
// load; evt_ready returns in the same cycle as res_valid, so a new event is
// taken only once the last one is through. An exit that runs the shutoff check
// adds the check unit: 64 remainder steps, and if the entry count is a multiple
// of the interval, 64 product steps and a compare, one bit per cycle on its
// shared 49-bit adder. evt_ready is high only while no event is in work. A
// stalled receiver holds the result word in the output register; the next event
// is still taken and waits at write-back until the output register is free.
// Reset: all rows read as zero through per-row valid bits, no clearing pass;
// registers return to their reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module function_time_profiler (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       evt_valid,
	output logic                            evt_ready,
	input  wire logic [1:0]                 cmd,
	input  wire logic [7:0]                 func_index,
	input  wire logic [63:0]                timestamp,
	output logic                            res_valid,
	input  wire logic                       res_ready,
	output logic                            status,
	output logic                            shutoff_now,
	output logic                            shutoff_flag,
	output logic      [63:0]                accumulated_cycles,
	output logic      [63:0]                entry_total,
	output logic      [15:0]                nesting_depth,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [ftp_pkg::APB_AW-1:0] paddr,
	input  wire logic [ftp_pkg::APB_DW-1:0] pwdata,
	output logic      [ftp_pkg::APB_DW-1:0] prdata,
	output logic                            pready
);
	import ftp_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_WRITE
	} state_t;

	state_t      state_q;
	logic [1:0]  cmd_q;
	logic [7:0]  idx_q;
	logic [63:0] ts_q;
	row_t        row_q;
	logic        status_q;
	logic        now_q;
	logic        res_valid_q;
	logic        res_status_q;
	logic        res_now_q;
	logic        res_flag_q;
	logic [63:0] res_acc_q;
	logic [63:0] res_count_q;
	logic [15:0] res_depth_q;

	cfg_t        cfg;
	chk_res_t    chk;
	row_t        rd_row;
	row_t        new_row;
	logic        status_c;
	logic        check_c;
	logic        idx_ok;
	logic        out_free;
	logic        load;
	logic        evt_take;

	ftp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ftp_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (evt_take),
		.rd_addr (func_index[FUNC_BITS-1:0]),
		.rd_row  (rd_row),
		.wr_en   (load && idx_ok),
		.wr_addr (idx_q[FUNC_BITS-1:0]),
		.wr_row  (row_q)
	);

	ftp_check u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    ((state_q == S_READ) && check_c),
		.count_in (new_row.count),
		.acc_in   (new_row.acc),
		.cfg      (cfg),
		.res      (chk)
	);

	assign evt_ready = (state_q == S_IDLE);
	assign evt_take  = evt_valid && evt_ready;
	assign idx_ok    = ({1'b0, idx_q} < 9'(FUNC_COUNT));
	assign out_free  = !res_valid_q || res_ready;
	assign load      = (state_q == S_WRITE) && out_free;

	// next row of the function from the event
	always_comb begin
		new_row  = rd_row;
		status_c = 1'b0;
		check_c  = 1'b0;
		unique case (cmd_q)
			CMD_ENTRY: begin
				if (rd_row.depth == '0) begin
					new_row.count = rd_row.count + 1'b1;
					new_row.start = ts_q;
				end
				if (rd_row.depth != DEPTH_MAX) begin
					new_row.depth = rd_row.depth + 1'b1;
				end
			end
			CMD_EXIT: begin
				if (rd_row.depth == '0) begin
					status_c = 1'b1;
				end else begin
					new_row.depth = rd_row.depth - 1'b1;
					if (rd_row.depth == DEPTH_BITS'(1)) begin
						new_row.acc   = rd_row.acc + (ts_q - rd_row.start);
						new_row.start = ts_q;
					end
					check_c = cfg.enable && (cfg.iter != '0) && (rd_row.count != '0);
				end
			end
			default: begin
			end
		endcase
		if (!idx_ok) begin
			new_row  = '0;
			status_c = 1'b0;
			check_c  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= CMD_READ;
			idx_q        <= '0;
			ts_q         <= '0;
			row_q        <= '0;
			status_q     <= 1'b0;
			now_q        <= 1'b0;
			res_valid_q  <= 1'b0;
			res_status_q <= 1'b0;
			res_now_q    <= 1'b0;
			res_flag_q   <= 1'b0;
			res_acc_q    <= '0;
			res_count_q  <= '0;
			res_depth_q  <= '0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (evt_valid) begin
						cmd_q   <= cmd;
						idx_q   <= func_index;
						ts_q    <= timestamp;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					row_q    <= new_row;
					status_q <= status_c;
					now_q    <= 1'b0;
					state_q  <= check_c ? S_CHECK : S_WRITE;
				end
				S_CHECK: begin
					if (chk.done) begin
						if (chk.below) begin
							row_q.shutoff <= 1'b1;
							now_q         <= 1'b1;
						end
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					// hold the row until the output register is free
					if (out_free) begin
						res_status_q <= status_q;
						res_now_q    <= now_q;
						res_flag_q   <= row_q.shutoff;
						res_acc_q    <= row_q.acc;
						res_count_q  <= row_q.count;
						res_depth_q  <= 16'(row_q.depth);
						state_q      <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign res_valid          = res_valid_q;
	assign status             = res_status_q;
	assign shutoff_now        = res_now_q;
	assign shutoff_flag       = res_flag_q;
	assign accumulated_cycles = res_acc_q;
	assign entry_total        = res_count_q;
	assign nesting_depth      = res_depth_q;

endmodule

`default_nettype wire

/* hw/rtl/ftp_checker.sv */
// ----------------------------------------------------------------------------
// ftp_checker: port-level checks of the function time profiler
// Watches the event and result channels and the result word fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ftp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        evt_valid,
	input wire logic        evt_ready,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic        status,
	input wire logic        shutoff_now,
	input wire logic        shutoff_flag,
	input wire logic [63:0] accumulated_cycles,
	input wire logic [63:0] entry_total,
	input wire logic [15:0] nesting_depth
);

	// a stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(accumulated_cycles)
			&& $stable(entry_total) && $stable(nesting_depth))
		else $error("result word changed while stalled");

	// one event in work at a time
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready |=> !evt_ready)
		else $error("event taken while another is in work");

	a_err_depth: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status |-> nesting_depth == 16'd0 && !shutoff_now)
		else $error("error word with depth or shutoff decision");

	a_now_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && shutoff_now |-> shutoff_flag)
		else $error("shutoff decision without sticky flag");

endmodule

bind function_time_profiler ftp_checker u_ftp_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.evt_valid          (evt_valid),
	.evt_ready          (evt_ready),
	.res_valid          (res_valid),
	.res_ready          (res_ready),
	.status             (status),
	.shutoff_now        (shutoff_now),
	.shutoff_flag       (shutoff_flag),
	.accumulated_cycles (accumulated_cycles),
	.entry_total        (entry_total),
	.nesting_depth      (nesting_depth)
);

`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench of the function time profiler
// Drives event words over the evt channel and settings over APB, and keeps
// its own copy of the per-function table. Every result word is compared field
// by field against the totals predicted for the oldest accepted event. It
// covers reset defaults, edge settings, a deep call nest, and random call
// nests under three idle mixes, one with a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	import ftp_pkg::*;

	localparam logic [1:0] CMD_SPARE     = 2'd3;
	localparam logic [7:0] NEST_FUNC     = 8'hA5;
	localparam int         NEST_DEPTH    = 40;
	localparam int         CYCLE_LIMIT   = 2_000_000;
	localparam int         SETTLE_CYCLES = 8;
	localparam int         TAIL_CYCLES   = 150;
	localparam int         PRINT_CAP     = 40;

	typedef struct packed {
		logic             status;
		logic             hit;
		logic             flag;
		logic [CNT_W-1:0] acc;
		logic [CNT_W-1:0] count;
		logic [15:0]      depth;
	} totals_t;

	// Mirror of the profiling table and the settings
	class call_ledger;
		row_t        rows [FUNC_COUNT];
		cfg_t        regs;
		totals_t     due_totals [$];
		int unsigned mismatches;
		int unsigned results_checked;
		int unsigned shutoffs_due;
		int unsigned exit_errors_due;

		function new();
			foreach (rows[i]) rows[i] = '0;
			regs.enable = 1'b0;
			regs.iter   = ITER_RESET;
			regs.thresh = THRESH_RESET;
			regs.cpu    = CPU_RESET;
		endfunction

		function void set_reg(logic [1:0] code, logic [31:0] value);
			case (code)
				REG_ENABLE: regs.enable = value[0];
				REG_ITER:   regs.iter   = value[ITER_W-1:0];
				REG_THRESH: regs.thresh = value[THR_W-1:0];
				REG_CPU:    regs.cpu    = value[CPU_W-1:0];
				default: ;
			endcase
		endfunction

		// acc / visits < thresh * cpu, cross-multiplied in 128 bits
		function bit average_below(logic [CNT_W-1:0] acc, logic [CNT_W-1:0] visits);
			logic [127:0] budget;
			if (visits == '0)
				return 1'b0;
			budget = 128'(regs.thresh) * 128'(regs.cpu) * 128'(visits);
			return budget > 128'(acc);
		endfunction

		function void note_event(logic [1:0] code, logic [7:0] f, logic [CNT_W-1:0] ts);
			row_t    r;
			totals_t t;
			r = rows[f];
			t = '0;
			if (code == CMD_ENTRY) begin
				if (r.depth == '0) begin
					r.count = r.count + 1'b1;
					r.start = ts;
				end
				if (r.depth != DEPTH_MAX)
					r.depth = r.depth + 1'b1;
			end else if (code == CMD_EXIT) begin
				if (r.depth == '0) begin
					t.status = 1'b1;
					exit_errors_due++;
				end else begin
					r.depth = r.depth - 1'b1;
					if (r.depth == '0) begin
						r.acc   = r.acc + (ts - r.start);
						r.start = ts;
					end
					if (regs.enable && regs.iter != '0 && (r.count % regs.iter) == '0 &&
						average_below(r.acc, r.count)) begin
						r.shutoff = 1'b1;
						t.hit     = 1'b1;
						shutoffs_due++;
					end
				end
			end
			// read and the spare code leave the row alone
			rows[f] = r;
			t.flag  = r.shutoff;
			t.acc   = r.acc;
			t.count = r.count;
			t.depth = r.depth[15:0];
			due_totals.push_back(t);
		endfunction

		task log_mismatch(string what);
			mismatches++;
			if (mismatches <= PRINT_CAP)
				$display("tb: mismatch at result %0d: %s", results_checked, what);
		endtask

		task check_totals(totals_t got);
			totals_t want;
			if (due_totals.size() == 0) begin
				log_mismatch("result word with no event pending");
				return;
			end
			want = due_totals.pop_front();
			results_checked++;
			if (got.status !== want.status)
				log_mismatch($sformatf("status %0b, want %0b", got.status, want.status));
			if (got.hit !== want.hit)
				log_mismatch($sformatf("shutoff_now %0b, want %0b", got.hit, want.hit));
			if (got.flag !== want.flag)
				log_mismatch($sformatf("shutoff_flag %0b, want %0b", got.flag, want.flag));
			if (got.acc !== want.acc)
				log_mismatch($sformatf("accumulated_cycles %0h, want %0h", got.acc, want.acc));
			if (got.count !== want.count)
				log_mismatch($sformatf("entry_total %0h, want %0h", got.count, want.count));
			if (got.depth !== want.depth)
				log_mismatch($sformatf("nesting_depth %0d, want %0d", got.depth, want.depth));
		endtask
	endclass

	logic                clk;
	logic                arst_n     = 1'b0;
	logic                evt_valid  = 1'b0;
	logic                evt_ready;
	logic [1:0]          cmd        = CMD_READ;
	logic [7:0]          func_index = '0;
	logic [63:0]         timestamp  = '0;
	logic                res_valid;
	logic                res_ready  = 1'b0;
	logic                status;
	logic                shutoff_now;
	logic                shutoff_flag;
	logic [63:0]         accumulated_cycles;
	logic [63:0]         entry_total;
	logic [15:0]         nesting_depth;
	logic                psel       = 1'b0;
	logic                penable    = 1'b0;
	logic                pwrite     = 1'b0;
	logic [APB_AW-1:0]   paddr      = '0;
	logic [APB_DW-1:0]   pwdata     = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	call_ledger  ledger = new();
	totals_t     seen;
	logic [63:0] ts_now;
	int          events_sent;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_len;
	int          hold_tag;
	int          hold_seen;
	int          hold_left;
	int unsigned cycle_count;

	function_time_profiler u_dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles", cycle_count);
			$display("tb: FAIL");
			$finish;
		end
	end

	// Receiver: random stalls, plus a hold-off counted down here
	always @(posedge clk) begin
		if (hold_tag != hold_seen) begin
			hold_seen = hold_tag;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (evt_valid && evt_ready)
				ledger.note_event(cmd, func_index, timestamp);
			if (res_valid && res_ready) begin
				seen.status = status;
				seen.hit    = shutoff_now;
				seen.flag   = shutoff_flag;
				seen.acc    = accumulated_cycles;
				seen.count  = entry_total;
				seen.depth  = nesting_depth;
				ledger.check_totals(seen);
			end
		end
	end

	// Offer one word, after a random gap; return at the edge that takes it
	task automatic send_event(input logic [1:0] c, input logic [7:0] f, input logic [63:0] ts);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_valid  <= 1'b1;
		cmd        <= c;
		func_index <= f;
		timestamp  <= ts;
		do @(posedge clk); while (!evt_ready);
		events_sent++;
	endtask

	task automatic visit(input logic [7:0] f, input logic [63:0] t0, input logic [63:0] t1);
		send_event(CMD_ENTRY, f, t0);
		send_event(CMD_EXIT, f, t1);
	endtask

	task automatic wait_drained();
		evt_valid <= 1'b0;
		@(posedge clk);
		while (ledger.due_totals.size() != 0)
			@(posedge clk);
	endtask

	// Setup and access cycle, then the bus returns to idle
	task automatic write_reg(input logic [1:0] code, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({code, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		ledger.set_reg(code, value);
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic en, input logic [31:0] iter,
			input logic [31:0] thr, input logic [31:0] cpu);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_ENABLE, 32'(en));
		write_reg(REG_ITER, iter);
		write_reg(REG_THRESH, thr);
		write_reg(REG_CPU, cpu);
	endtask

	function automatic logic [7:0] pick_func();
		int r;
		r = $urandom_range(9);
		if (r < 7)
			return 8'($urandom_range(5));
		else if (r < 9)
			return 8'hFA;
		return 8'($urandom_range(255));
	endfunction

	// One call nest of random depth, maybe wrapping a read and a call to a random function
	task automatic call_burst(input logic [7:0] f);
		int          depth;
		logic [7:0]  g;
		depth = $urandom_range(1, 3);
		repeat (depth) begin
			send_event(CMD_ENTRY, f, ts_now);
			ts_now = ts_now + 64'($urandom_range(300));
		end
		if ($urandom_range(9) < 3) begin
			g = pick_func();
			send_event(CMD_ENTRY, g, ts_now);
			ts_now = ts_now + 64'($urandom_range(300));
			send_event(CMD_EXIT, g, ts_now);
			ts_now = ts_now + 64'($urandom_range(300));
		end
		if ($urandom_range(9) < 2)
			send_event(CMD_READ, f, ts_now);
		repeat (depth) begin
			send_event(CMD_EXIT, f, ts_now);
			ts_now = ts_now + 64'($urandom_range(300));
		end
	endtask

	task automatic directed_edges();
		apply_settings(1'b1, 32'd1, 32'd5000, 32'd1);
		send_event(CMD_EXIT, 8'd0, 64'd10);
		send_event(CMD_ENTRY, 8'd0, 64'd0);
		send_event(CMD_ENTRY, 8'd0, 64'd50);
		// nested exit still runs the check
		send_event(CMD_EXIT, 8'd0, 64'd80);
		// flag already set: fires again
		send_event(CMD_EXIT, 8'd0, 64'd200);
		send_event(CMD_READ, 8'd0, '1);
		send_event(CMD_SPARE, 8'd0, 64'd0);
		// elapsed time wraps past the top of the counter
		visit(8'd255, '1, 64'd5);
		visit(8'd1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFE);
		send_event(CMD_EXIT, 8'd1, 64'd0);
		apply_settings(1'b1, 32'd0, 32'd5000, 32'd1);
		visit(8'd2, 64'd0, 64'd1);
		apply_settings(1'b1, 32'd1, 32'd5000, 32'd0);
		visit(8'd2, 64'd10, 64'd11);
		apply_settings(1'b1, 32'd1, 32'd0, 32'd65535);
		visit(8'd2, 64'd20, 64'd21);
		apply_settings(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd65535);
		visit(8'd2, 64'd30, 64'd31);
		apply_settings(1'b1, 32'd1, 32'hFFFF_FFFF, 32'd65535);
		visit(8'd2, 64'd40, 64'd41);
	endtask

	task automatic deep_nest();
		apply_settings(1'b0, 32'd7, 32'd1, 32'd1);
		ts_now = 64'h8000_0000_0000_0000;
		// a long run of entries into one function without an exit
		repeat (NEST_DEPTH) begin
			send_event(CMD_ENTRY, NEST_FUNC, ts_now);
			ts_now = ts_now + 64'd3;
		end
		send_event(CMD_EXIT, NEST_FUNC, ts_now);
		send_event(CMD_READ, NEST_FUNC, ts_now);
	endtask

	task automatic random_phase(input logic en, input logic [31:0] iter,
			input logic [31:0] thr, input logic [31:0] cpu, input int words,
			input int s_pct, input int r_pct, input bit squeeze);
		int first;
		bit squeezed;
		apply_settings(en, iter, thr, cpu);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		ts_now        = {$urandom, $urandom};
		first         = events_sent;
		squeezed      = 1'b0;
		while (events_sent - first < words) begin
			if (squeeze && !squeezed && events_sent - first > words / 3) begin
				// hold the receiver while words keep coming, then drain fully
				squeezed      = 1'b1;
				hold_len      = 300;
				hold_tag++;
				send_idle_pct = 0;
				repeat (4) call_burst(pick_func());
				send_idle_pct = s_pct;
				wait_drained();
			end else if ($urandom_range(99) < 25)
				send_event(2'($urandom_range(CMD_SPARE)), 8'($urandom_range(255)),
					{$urandom, $urandom});
			else
				call_burst(pick_func());
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;

		// reset interval, threshold and rate: fires on the hundredth exit
		write_reg(REG_ENABLE, 32'd1);
		ts_now = 64'd0;
		repeat (100) begin
			visit(8'd3, ts_now, ts_now + 64'd1000);
			ts_now = ts_now + 64'd1001;
		end

		directed_edges();
		deep_nest();
		random_phase(1'b1, 32'd3, 32'd7, 32'd60, 130, 22, 45, 1'b1);
		random_phase(1'b1, 32'd1, 32'd2, 32'd300, 130, 45, 22, 1'b0);
		random_phase(1'b1, 32'd4, 32'd3, 32'd150, 130, 0, 0, 1'b0);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("tb: %0d event words, %0d results checked, %0d shutoff decisions, %0d exit errors",
			events_sent, ledger.results_checked, ledger.shutoffs_due, ledger.exit_errors_due);
		$display("tb: reset defaults, edge settings, a deep nest, three idle mixes, hold-off");
		if (ledger.mismatches == 0 && ledger.due_totals.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
